>>> rtl/acs_pkg.sv
`timescale 1ns / 1ps
package acs_pkg;

   // Q4.28 constants
   localparam int Q_FRAC = 28;
   localparam logic signed [34:0] Q_ONE        = 35'sd268435456;
   localparam logic signed [34:0] Q_EPS6       = 35'sd268;
   localparam logic signed [34:0] Q_EPS5       = 35'sd2684;
   localparam logic signed [34:0] Q_SLOPE_LEFT = 35'sd2684355;
   localparam logic signed [34:0] Q_BETA_MAX   = 35'sd265751101;
   localparam logic signed [34:0] Q_BETA_DEF   = 35'sd80530637;

   // divider sizing: numerator magnitude bits, then the Q_FRAC shifted-in zeros
   localparam int DIV_W = 34;
   localparam int QUO_W = DIV_W + Q_FRAC;
   localparam int CNT_W = $clog2(QUO_W);

   // CSR register indexes
   typedef enum logic [2:0] {
      CSR_REST_SEP   = 3'd0,
      CSR_BREAK_RAT  = 3'd1,
      CSR_MIN_BREAK  = 3'd2,
      CSR_BLEND_HALF = 3'd3,
      CSR_PULL_GAP   = 3'd4,
      CSR_NEUTRAL    = 3'd5
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TOL, ST_CHK, ST_BETA, ST_BDIV, ST_REGION, ST_LIN, ST_LSUM,
      ST_TDIV, ST_T2, ST_T3, ST_T4, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6,
      ST_OUT
   } state_type;

endpackage

>>> rtl/acs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: quot = (num << Q_FRAC) / den
module acs_div import acs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quot
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [QUO_W-1:0] sh_ff;
   logic [DIV_W:0]   rem_ff;
   logic [QUO_W-1:0] quot_ff;
   logic [DIV_W-1:0] den_ff;
   logic [DIV_W:0]   trial;
   logic             fits;

   // trial subtract of the next bit
   assign trial = {rem_ff[DIV_W-1:0], sh_ff[QUO_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff   <= {num, {Q_FRAC{1'b0}}};
         rem_ff  <= '0;
         quot_ff <= '0;
         den_ff  <= den;
      end else if (busy_ff) begin
         sh_ff   <= {sh_ff[QUO_W-2:0], 1'b0};
         rem_ff  <= fits ? (trial - {1'b0, den_ff}) : trial;
         quot_ff <= {quot_ff[QUO_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/adhesion_constraint_scalar_core.sv
`timescale 1ns / 1ps
// Adhesion constraint scalar core.
// req_ channel: one beat per solver iteration, tdata = separation (Q4.28),
//   tuser = separation_bad. req_tready is high only while the core is idle.
// rsp_ channel: one beat per request, tdata = cval and slope_factor,
//   tuser = broken and used_fallback.
// csr_ channel: register writes, always ready; write only while idle.
// Path from the request beat to rsp_tvalid: direct to ST_OUT when the break
//   latch is already set; on a fresh break, through the tolerance product and
//   the break check. Otherwise a beta division (skipped when the neutral gap
//   is tiny), then a short linear path or a second blend division plus the
//   multiply chain. The two divisions run serially through the shared radix-2
//   divider; all products go through one shared multiplier, one per cycle.
// The next request is taken in the cycle after the result loads.
// Reset clears the break latch, the held slope factor and the registers to
//   their defaults (break ratio 3.0).
// Stall: a finished result waits in the output register; the core takes
//   the next request meanwhile and holds its own result until the beat goes.
module adhesion_constraint_scalar_core import acs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] separation, [31] zero
   input  logic        req_tuser,   // [0] separation_bad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] cval, [60:32] slope_factor
   output logic [1:0]  rsp_tuser,   // [0] broken, [1] used_fallback
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   state_type state_ff, state_in;

   logic [30:0] rest_ff, ratio_ff, minbrk_ff, half_ff, pull_ff, neutral_ff;
   logic        latch_ff;
   logic [28:0] last_sf_ff;

   logic [30:0]        d_ff;
   logic               fb_ff, brk_ff;
   logic signed [34:0] de_ff, beta_ff, delta_ff, x_ff, w_ff, t_ff, t2_ff, t3_ff;
   logic signed [34:0] blend_ff, slope_ff;
   logic signed [41:0] p_ff;
   logic signed [43:0] acc_ff;

   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   logic signed [34:0] mul_a, mul_b;
   logic               div_start;
   logic [DIV_W-1:0]   div_num, div_den;
   logic               div_done;
   logic [QUO_W-1:0]   div_quot;

   logic               req_fire, out_load;
   logic signed [34:0] d0_s, lo, hi, delta_c, stretch;
   logic signed [41:0] limit;
   logic               fb_c, in_lo, in_hi, brk_now;
   logic signed [43:0] cval;
   logic [31:0]        cval_sat;
   logic signed [34:0] sf_full;

   assign req_fire  = req_tvalid && req_tready;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready = 1'b1;

   // curve geometry
   assign d0_s    = 35'($unsigned(rest_ff));
   assign delta_c = (35'($unsigned(half_ff)) < Q_EPS5) ? Q_EPS5 : 35'($unsigned(half_ff));
   assign lo      = d0_s - delta_ff;
   assign hi      = d0_s + delta_ff;
   assign in_lo   = de_ff < lo;
   assign in_hi   = de_ff > hi;
   assign fb_c    = req_tuser || (35'($unsigned(req_tdata[30:0])) > Q_ONE) ||
                    (35'($unsigned(req_tdata[30:0])) < Q_EPS6);
   assign stretch = 35'($unsigned(d_ff)) - d0_s;
   assign limit   = (p_ff > $signed(42'(minbrk_ff))) ? p_ff : $signed(42'(minbrk_ff));
   assign brk_now = !fb_ff && (42'(stretch) > limit);

   // shared rounding Q4.28 multiplier
   logic [34:0] ua, ub;
   logic [69:0] prod;
   logic [41:0] mag;
   logic signed [41:0] mul_res;
   always_comb begin
      ua      = mul_a[34] ? 35'(-mul_a) : 35'(mul_a);
      ub      = mul_b[34] ? 35'(-mul_b) : 35'(mul_b);
      prod    = 70'(ua) * 70'(ub);
      prod    = prod + 70'd134217728;
      mag     = prod[69:28];
      mul_res = (mul_a[34] != mul_b[34]) ? -$signed(mag) : $signed(mag);
   end

   acs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = latch_ff ? ST_OUT : ST_TOL;
         ST_TOL:    state_in = ST_CHK;
         ST_CHK:    state_in = brk_now ? ST_OUT : ST_BETA;
         ST_BETA:   state_in = (35'($unsigned(neutral_ff)) <= Q_EPS6) ? ST_REGION : ST_BDIV;
         ST_BDIV:   if (div_done) state_in = ST_REGION;
         ST_REGION: state_in = (in_lo || in_hi) ? ST_LIN : ST_TDIV;
         ST_LIN:    state_in = ST_LSUM;
         ST_LSUM:   state_in = ST_OUT;
         ST_TDIV:   if (div_done) state_in = ST_T2;
         ST_T2:     state_in = ST_T3;
         ST_T3:     state_in = ST_T4;
         ST_T4:     state_in = ST_K1;
         ST_K1:     state_in = ST_K2;
         ST_K2:     state_in = ST_K3;
         ST_K3:     state_in = ST_K4;
         ST_K4:     state_in = ST_K5;
         ST_K5:     state_in = ST_K6;
         ST_K6:     state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // unit controls per step
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      div_num    = DIV_W'(pull_ff);
      div_den    = DIV_W'(neutral_ff);
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_TOL: begin
            mul_a = d0_s;
            mul_b = 35'($unsigned(ratio_ff)) - Q_ONE;
         end
         ST_BETA: div_start = (35'($unsigned(neutral_ff)) > Q_EPS6);
         ST_REGION: begin
            div_start = !(in_lo || in_hi);
            div_num   = DIV_W'(de_ff - lo);
            div_den   = DIV_W'(delta_ff <<< 1);
         end
         ST_LIN: begin
            mul_a = slope_ff;
            mul_b = de_ff - d0_s;
         end
         ST_T2: begin
            mul_a = t_ff;
            mul_b = t_ff;
         end
         ST_T3, ST_T4: begin
            mul_a = p_ff[34:0];
            mul_b = t_ff;
         end
         ST_K1: begin
            mul_a = beta_ff - Q_SLOPE_LEFT;
            mul_b = 35'(3) * t2_ff - 35'(2) * t3_ff;
         end
         ST_K2: begin
            mul_a = Q_SLOPE_LEFT;
            mul_b = delta_ff;
         end
         ST_K3: begin
            mul_a = Q_SLOPE_LEFT;
            mul_b = x_ff;
         end
         ST_K4: begin
            mul_a = beta_ff - Q_SLOPE_LEFT;
            mul_b = w_ff;
         end
         ST_K5: begin
            mul_a = p_ff[34:0];
            mul_b = blend_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rest_ff      <= '0;
         ratio_ff     <= 31'd805306368;
         minbrk_ff    <= '0;
         half_ff      <= '0;
         pull_ff      <= '0;
         neutral_ff   <= '0;
         latch_ff     <= 1'b0;
         last_sf_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REST_SEP:   rest_ff    <= csr_data[30:0];
               CSR_BREAK_RAT:  ratio_ff   <= csr_data[30:0];
               CSR_MIN_BREAK:  minbrk_ff  <= csr_data[30:0];
               CSR_BLEND_HALF: half_ff    <= csr_data[30:0];
               CSR_PULL_GAP:   pull_ff    <= csr_data[30:0];
               CSR_NEUTRAL:    neutral_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         if (state_ff == ST_CHK && brk_now) latch_ff <= 1'b1;
         if (out_load && !brk_ff && !fb_ff) last_sf_ff <= sf_full[28:0];
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // result formatting
   always_comb begin
      cval     = 44'(de_ff) - acc_ff;
      if (cval > 44'sd2147483647) cval_sat = 32'h7FFFFFFF;
      else if (cval < -44'sd2147483648) cval_sat = 32'h80000000;
      else cval_sat = cval[31:0];
      sf_full  = Q_ONE - slope_ff;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      p_ff <= mul_res;
      case (state_ff)
         ST_IDLE: if (req_fire) begin
            d_ff   <= req_tdata[30:0];
            fb_ff  <= fb_c;
            brk_ff <= latch_ff;
            de_ff  <= fb_c ? 35'($unsigned(rest_ff)) : 35'($unsigned(req_tdata[30:0]));
         end
         ST_CHK:  if (brk_now) brk_ff <= 1'b1;
         ST_BETA: begin
            beta_ff  <= Q_BETA_DEF;
            delta_ff <= delta_c;
         end
         ST_BDIV: if (div_done) begin
            if (div_quot > QUO_W'(Q_BETA_MAX)) beta_ff <= Q_BETA_MAX;
            else if (div_quot < QUO_W'(Q_SLOPE_LEFT)) beta_ff <= Q_SLOPE_LEFT;
            else beta_ff <= 35'(div_quot);
         end
         ST_REGION: begin
            slope_ff <= in_lo ? Q_SLOPE_LEFT : beta_ff;
            x_ff     <= de_ff - lo;
            w_ff     <= delta_ff <<< 1;
         end
         ST_LSUM: acc_ff <= 44'(d0_s) + 44'(p_ff);
         ST_TDIV: if (div_done)
            t_ff <= (div_quot > QUO_W'(Q_ONE)) ? Q_ONE : 35'(div_quot);
         ST_T3:   t2_ff <= p_ff[34:0];
         ST_T4:   t3_ff <= p_ff[34:0];
         ST_K1:   blend_ff <= t3_ff - (p_ff[34:0] >>> 1);
         ST_K2:   slope_ff <= Q_SLOPE_LEFT + p_ff[34:0];
         ST_K3:   acc_ff <= 44'(d0_s) - 44'(p_ff);
         ST_K4, ST_K6: acc_ff <= acc_ff + 44'(p_ff);
         ST_OUT: if (out_load) begin
            if (brk_ff) begin
               rsp_data_ff <= '0;
               rsp_user_ff <= 2'b01;
            end else begin
               rsp_data_ff <= {3'b000, fb_ff ? last_sf_ff : sf_full[28:0], cval_sat};
               rsp_user_ff <= {fb_ff, 1'b0};
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> rtl/acs_checker.sv
`timescale 1ns / 1ps
module acs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a broken beat never claims fallback
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("broken and fallback both set");

   // broken beats carry zero value and zero slope
   a_broken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("broken beat with nonzero data");

   // slope factor never exceeds one
   a_sf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[60:32] <= 29'd268435456)
      else $error("slope factor out of range");

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled beat changed");

endmodule

bind adhesion_constraint_scalar_core acs_checker u_acs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
